// ----- sv/lcf_pkg.sv -----
// shared types, codes and activation table arithmetic for the lstm cell
package lcf_pkg;

    localparam int DATA_W = 16;
    localparam int ACC_W  = 40;

    localparam int MAX_INPUTS  = 16;
    localparam int MAX_OUTPUTS = 16;

    localparam logic [1:0] KIND_WEIGHT = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_CLEAR  = 2'd2;

    localparam logic REG_INPUT_COUNT  = 1'b0;
    localparam logic REG_OUTPUT_COUNT = 1'b1;

    localparam logic [1:0] GATE_Z    = 2'd2;
    localparam logic [1:0] GATE_LAST = 2'd3;

    localparam logic signed [DATA_W-1:0] Q_ONE = 16'sd4096;

    localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
    localparam logic [63:0] E_INV_Q32 = 64'd1580030169;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctl_t;

    // restoring division, used only while building the tables
    function automatic logic [63:0] udiv(input logic [63:0] num, input logic [63:0] den);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], num[b]};
            if (rem >= {1'b0, den})
            begin
                rem = rem - {1'b0, den};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // e^-(y/4096) in q32
    function automatic logic [63:0] exp_neg(input logic [31:0] y);
        logic [31:0] n;
        logic [63:0] f;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] r;
        n = y >> 12;
        f = {52'd0, y[11:0]};
        term = ONE_Q32;
        sum = ONE_Q32;
        for (int k = 1; k <= 12; k++)
        begin
            term = udiv(term * f, 64'(4096 * k));
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        r = sum;
        for (int k = 0; k < 32; k++)
        begin
            if (32'(k) < n)
                r = (r * E_INV_Q32) >> 32;
        end
        return r;
    endfunction

    // table entry k: sigmoid or tanh at the midpoint of its interval
    function automatic logic [15:0] act_entry(input logic is_tanh, input int unsigned k,
                                              input int unsigned depth);
        logic [63:0] mid;
        logic        neg;
        logic [31:0] mag;
        logic [63:0] e;
        logic [63:0] den;
        logic [63:0] res;
        mid = udiv(64'((2 * k + 1) * 32768), 64'(depth));
        neg = (mid < 64'd32768);
        mag = neg ? 32'(64'd32768 - mid) : 32'(mid - 64'd32768);
        if (is_tanh)
        begin
            e = exp_neg(2 * mag);
            den = ONE_Q32 + e;
            res = udiv((ONE_Q32 - e) * 64'd4096 + (den >> 1), den);
            if (neg)
                res = 64'd0 - res;
        end
        else
        begin
            e = exp_neg(mag);
            den = ONE_Q32 + e;
            res = udiv((64'd1 << 44) + (den >> 1), den);
            if (neg)
                res = 64'd4096 - res;
        end
        return res[15:0];
    endfunction

endpackage

// ----- sv/lcf_mac.sv -----
// shared multiply-accumulate unit with 40-bit saturation and q4.12 rounding
module lcf_mac (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lcf_pkg::mac_ctl_t       ctl,
    input  logic signed [15:0]      a,
    input  logic signed [15:0]      b,
    output logic                    done,
    output logic signed [15:0]      q
);
    import lcf_pkg::*;

    mac_ctl_t                   ctl_reg;
    logic signed [31:0]         prod_reg;
    logic signed [ACC_W-1:0]    acc_reg;
    logic                       done_reg;
    logic signed [ACC_W:0]      sum;
    logic signed [ACC_W-1:0]    acc_next;
    logic signed [ACC_W:0]      rnd;
    logic signed [ACC_W-12:0]   shifted;

    always_comb
    begin
        sum = (ctl_reg.first ? (ACC_W+1)'(0) : (ACC_W+1)'(acc_reg)) + (ACC_W+1)'(prod_reg);
        if (sum[ACC_W] != sum[ACC_W-1])
            acc_next = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        else
            acc_next = sum[ACC_W-1:0];
    end

    // round to nearest, floor shift, clamp to 16 bits
    always_comb
    begin
        rnd = (ACC_W+1)'(acc_reg) + (ACC_W+1)'(2048);
        shifted = rnd[ACC_W:12];
        if (shifted > (ACC_W-11)'(32767))
            q = 16'sh7fff;
        else if (shifted < -(ACC_W-11)'(32768))
            q = 16'sh8000;
        else
            q = shifted[15:0];
    end

    assign done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg  <= '0;
            prod_reg <= '0;
            acc_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            ctl_reg  <= ctl;
            prod_reg <= a * b;
            if (ctl_reg.valid)
                acc_reg <= acc_next;
            done_reg <= ctl_reg.valid & ctl_reg.last;
        end
    end

endmodule

// ----- sv/lcf_act_rom.sv -----
// sigmoid and tanh lookup tables with registered read
module lcf_act_rom #(
    parameter int ACT_TABLE_DEPTH = 1024
) (
    input  logic                clk,
    input  logic                sel_tanh,
    input  logic signed [15:0]  x,
    output logic signed [15:0]  y
);
    import lcf_pkg::*;

    localparam int TW = $clog2(ACT_TABLE_DEPTH);
    localparam int PW = 16 + $clog2(ACT_TABLE_DEPTH + 1);

    typedef logic [15:0] tab_t [ACT_TABLE_DEPTH];

    function automatic tab_t build_tab(input logic is_tanh);
        tab_t t;
        for (int k = 0; k < ACT_TABLE_DEPTH; k++)
            t[k] = act_entry(is_tanh, k, ACT_TABLE_DEPTH);
        return t;
    endfunction

    localparam tab_t SIG_TAB  = build_tab(1'b0);
    localparam tab_t TANH_TAB = build_tab(1'b1);

    logic [15:0]    biased;
    logic [PW-1:0]  scaled;
    logic [PW-17:0] top;
    logic [TW-1:0]  idx;
    logic [15:0]    y_reg;

    always_comb
    begin
        biased = {~x[15], x[14:0]};
        scaled = PW'(biased) * PW'(ACT_TABLE_DEPTH);
        top = scaled[PW-1:16];
        if (top >= (PW-16)'(ACT_TABLE_DEPTH))
            idx = TW'(ACT_TABLE_DEPTH - 1);
        else
            idx = top[TW-1:0];
    end

    always_ff @(posedge clk)
    begin
        y_reg <= sel_tanh ? TANH_TAB[idx] : SIG_TAB[idx];
    end

    assign y = y_reg;

endmodule

// ----- sv/lstm_cell_forward.sv -----
// lstm cell forward step: weight store, sequencer and shared datapath
// A step starts on the sample word marked last and runs all gate dot products
// and the cell update through one multiply-accumulate unit, one product per
// cycle while a dot product issues, with waits for the drain between them and
// for a held output. Its length is set by the single multiplier and the drain
// after each dot product. Input is not accepted during a step. The hidden
// words leave through an output register, one per unit, unit 0 first.
module lstm_cell_forward #(
    parameter int ACT_TABLE_DEPTH = 1024
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,    // weight_addr, weight_value, sample, zero pad
    input  logic [1:0]  s_tuser,    // kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // hidden_value, hidden_index, zero pad
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lcf_pkg::*;

    localparam int MI   = MAX_INPUTS;
    localparam int MO   = MAX_OUTPUTS;
    localparam int GX   = MO * MI;
    localparam int GW   = MO * (MI + MO);
    localparam int BB   = 4 * GW;
    localparam int WW   = BB + 4 * MO;
    localparam int WA   = $clog2(WW);
    localparam int IA   = $clog2(MI);
    localparam int OA   = $clog2(MO);
    localparam int CA   = $clog2(MI + 1);
    localparam int OCW  = $clog2(MO + 1);
    localparam int GA   = $clog2(4 * MO);

    typedef enum logic [3:0] {
        ST_IDLE, ST_GX, ST_GH, ST_GB, ST_GWAIT, ST_GWR,
        ST_CRD, ST_CM1A, ST_CM1B, ST_CWAIT1, ST_CMAC2, ST_CWAIT2, ST_COUT
    } state_t;

    typedef enum logic [1:0] {B_BUF, B_HIST, B_IMM} bsrc_t;

    // configuration
    logic [4:0] cfg_in_reg;
    logic [4:0] cfg_out_reg;

    // sequencer state
    state_t             state_reg;
    logic [IA-1:0]      i_reg;
    logic [OA-1:0]      j_reg;
    logic [OA-1:0]      o_reg;
    logic [1:0]         g_reg;
    logic [2:0]         p_reg;
    logic [CA-1:0]      ni_reg;
    logic [OCW-1:0]     no_reg;
    logic [CA-1:0]      ecount_reg;
    logic               comb_phase_reg;
    logic [WA-1:0]      gbase_reg;
    logic [WA-1:0]      xbase_reg;
    logic [WA-1:0]      hbase_reg;
    logic [WA-1:0]      bgbase_reg;
    logic [WA-1:0]      bptr_reg;
    logic [GA-1:0]      ggbase_reg;
    logic [GA-1:0]      gptr_reg;
    logic [GA-1:0]      crptr_reg;
    logic signed [15:0] hold_reg [4];
    logic signed [15:0] c_hold_reg;

    // output word
    logic               out_valid_reg;
    logic signed [15:0] out_value_reg;
    logic [3:0]         out_index_reg;
    logic               out_last_reg;

    // memories
    logic signed [15:0] weight_mem [WW];
    logic signed [15:0] weight_rd_reg;
    logic signed [15:0] buf_mem [MI];
    logic signed [15:0] buf_rd_reg;
    logic signed [15:0] hist_mem [MO];
    logic signed [15:0] hist_rd_reg;
    logic               hist_rv_reg;
    logic [MO-1:0]      hist_vld_reg;
    logic signed [15:0] cell_mem [MO];
    logic signed [15:0] cell_rd_reg;
    logic               cell_rv_reg;
    logic [MO-1:0]      cell_vld_reg;
    logic signed [15:0] gate_mem [4 * MO];
    logic signed [15:0] gate_rd_reg;

    // operand stage
    mac_ctl_t           s1_ctl_reg;
    logic               s1_asrc_reg;
    bsrc_t              s1_bsrc_reg;
    logic signed [15:0] s1_aimm_reg;
    logic signed [15:0] s1_bimm_reg;

    logic               accept;
    logic [1:0]         in_kind;
    logic [11:0]        in_waddr;
    logic signed [15:0] in_wvalue;
    logic signed [15:0] in_sample;
    logic               w_we;
    logic [WA-1:0]      w_raddr;
    logic               buf_we;
    logic               hist_we;
    logic               cell_we;
    logic               gate_we;
    logic               out_free;
    logic               clear_acc;
    mac_ctl_t           iss_ctl;
    logic               iss_asrc;
    bsrc_t              iss_bsrc;
    logic signed [15:0] iss_aimm;
    logic signed [15:0] iss_bimm;
    logic signed [15:0] a_op;
    logic signed [15:0] b_op;
    logic               mac_done;
    logic signed [15:0] mac_q;
    logic               rom_tanh;
    logic signed [15:0] rom_y;
    logic               i_end;
    logic               j_end;
    logic               o_end;
    logic               cfg_we;

    assign in_kind   = s_tuser;
    assign in_waddr  = s_tdata[11:0];
    assign in_wvalue = s_tdata[27:12];
    assign in_sample = s_tdata[43:28];

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign clear_acc = accept && (in_kind == KIND_CLEAR);
    assign out_free  = !out_valid_reg || m_tready;

    assign w_we    = accept && (in_kind == KIND_WEIGHT) && (32'(in_waddr) < 32'(WW));
    assign buf_we  = accept && (in_kind == KIND_SAMPLE) && (32'(ecount_reg) < 32'(MI));
    assign gate_we = (state_reg == ST_GWR);
    assign cell_we = (state_reg == ST_CWAIT1) && mac_done;
    assign hist_we = (state_reg == ST_COUT) && out_free;

    assign i_end = (CA'(i_reg) + CA'(1) == ni_reg);
    assign j_end = (OCW'(j_reg) + OCW'(1) == no_reg);
    assign o_end = (OCW'(o_reg) + OCW'(1) == no_reg);

    assign rom_tanh = comb_phase_reg || (g_reg == GATE_Z);

    // apb
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_OUTPUT_COUNT) ? {27'd0, cfg_out_reg} : {27'd0, cfg_in_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_in_reg  <= 5'd16;
            cfg_out_reg <= 5'd16;
        end
        else if (cfg_we)
        begin
            if (paddr[2] == REG_INPUT_COUNT)
                cfg_in_reg <= pwdata[4:0];
            else
                cfg_out_reg <= pwdata[4:0];
        end
    end

    // weight read address per term
    always_comb
    begin
        case (state_reg)
            ST_GX:   w_raddr = xbase_reg + WA'(i_reg);
            ST_GH:   w_raddr = hbase_reg + WA'(j_reg);
            ST_GB:   w_raddr = bptr_reg;
            default: w_raddr = xbase_reg;
        endcase
    end

    // term issue
    always_comb
    begin
        iss_ctl  = '0;
        iss_asrc = 1'b1;
        iss_bsrc = B_IMM;
        iss_aimm = '0;
        iss_bimm = '0;
        case (state_reg)
            ST_GX:
            begin
                iss_ctl.valid = 1'b1;
                iss_ctl.first = (i_reg == '0);
                iss_bsrc = (CA'(i_reg) < ecount_reg) ? B_BUF : B_IMM;
            end
            ST_GH:
            begin
                iss_ctl.valid = 1'b1;
                iss_bsrc = B_HIST;
            end
            ST_GB:
            begin
                iss_ctl.valid = 1'b1;
                iss_ctl.last = 1'b1;
                iss_bimm = Q_ONE;
            end
            ST_CM1A:
            begin
                iss_ctl.valid = 1'b1;
                iss_ctl.first = 1'b1;
                iss_asrc = 1'b0;
                iss_aimm = hold_reg[0];
                iss_bimm = c_hold_reg;
            end
            ST_CM1B:
            begin
                iss_ctl.valid = 1'b1;
                iss_ctl.last = 1'b1;
                iss_asrc = 1'b0;
                iss_aimm = hold_reg[1];
                iss_bimm = hold_reg[2];
            end
            ST_CMAC2:
            begin
                iss_ctl.valid = 1'b1;
                iss_ctl.first = 1'b1;
                iss_ctl.last = 1'b1;
                iss_asrc = 1'b0;
                iss_aimm = hold_reg[3];
                iss_bimm = rom_y;
            end
            default:
            begin
                iss_ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg  <= '0;
            s1_asrc_reg <= 1'b0;
            s1_bsrc_reg <= B_IMM;
            s1_aimm_reg <= '0;
            s1_bimm_reg <= '0;
        end
        else
        begin
            s1_ctl_reg  <= iss_ctl;
            s1_asrc_reg <= iss_asrc;
            s1_bsrc_reg <= iss_bsrc;
            s1_aimm_reg <= iss_aimm;
            s1_bimm_reg <= iss_bimm;
        end
    end

    always_comb
    begin
        a_op = s1_asrc_reg ? weight_rd_reg : s1_aimm_reg;
        case (s1_bsrc_reg)
            B_BUF:   b_op = buf_rd_reg;
            B_HIST:  b_op = hist_rv_reg ? hist_rd_reg : 16'sd0;
            default: b_op = s1_bimm_reg;
        endcase
    end

    lcf_mac u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (s1_ctl_reg),
        .a     (a_op),
        .b     (b_op),
        .done  (mac_done),
        .q     (mac_q)
    );

    lcf_act_rom #(
        .ACT_TABLE_DEPTH (ACT_TABLE_DEPTH)
    ) u_act_rom (
        .clk      (clk),
        .sel_tanh (rom_tanh),
        .x        (mac_q),
        .y        (rom_y)
    );

    // memories
    always_ff @(posedge clk)
    begin
        if (w_we)
            weight_mem[WA'(in_waddr)] <= in_wvalue;
        weight_rd_reg <= weight_mem[w_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (buf_we)
            buf_mem[ecount_reg[IA-1:0]] <= in_sample;
        buf_rd_reg <= buf_mem[i_reg];
    end

    always_ff @(posedge clk)
    begin
        if (hist_we)
            hist_mem[o_reg] <= mac_q;
        hist_rd_reg <= hist_mem[j_reg];
        hist_rv_reg <= hist_vld_reg[j_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cell_we)
            cell_mem[o_reg] <= mac_q;
        cell_rd_reg <= cell_mem[o_reg];
        cell_rv_reg <= cell_vld_reg[o_reg];
    end

    always_ff @(posedge clk)
    begin
        if (gate_we)
            gate_mem[gptr_reg] <= rom_y;
        gate_rd_reg <= gate_mem[crptr_reg];
    end

    // written marks for cell and hidden state, zero when clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hist_vld_reg <= '0;
            cell_vld_reg <= '0;
        end
        else if (clear_acc)
        begin
            hist_vld_reg <= '0;
            cell_vld_reg <= '0;
        end
        else
        begin
            if (hist_we)
                hist_vld_reg[o_reg] <= 1'b1;
            if (cell_we)
                cell_vld_reg[o_reg] <= 1'b1;
        end
    end

    // sequencer and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            i_reg          <= '0;
            j_reg          <= '0;
            o_reg          <= '0;
            g_reg          <= '0;
            p_reg          <= '0;
            ni_reg         <= '0;
            no_reg         <= '0;
            ecount_reg     <= '0;
            comb_phase_reg <= 1'b0;
            gbase_reg      <= '0;
            xbase_reg      <= '0;
            hbase_reg      <= '0;
            bgbase_reg     <= '0;
            bptr_reg       <= '0;
            ggbase_reg     <= '0;
            gptr_reg       <= '0;
            crptr_reg      <= '0;
            for (int k = 0; k < 4; k++)
                hold_reg[k] <= '0;
            c_hold_reg     <= '0;
            out_valid_reg  <= 1'b0;
            out_value_reg  <= '0;
            out_index_reg  <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && m_tready && !hist_we)
                out_valid_reg <= 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (in_kind == KIND_CLEAR)
                            ecount_reg <= '0;
                        else if (in_kind == KIND_SAMPLE)
                        begin
                            if (buf_we)
                                ecount_reg <= ecount_reg + CA'(1);
                            if (s_tlast)
                            begin
                                if (cfg_in_reg == 5'd0)
                                    ni_reg <= CA'(1);
                                else if (32'(cfg_in_reg) > 32'(MI))
                                    ni_reg <= CA'(MI);
                                else
                                    ni_reg <= CA'(cfg_in_reg);
                                if (cfg_out_reg == 5'd0)
                                    no_reg <= OCW'(1);
                                else if (32'(cfg_out_reg) > 32'(MO))
                                    no_reg <= OCW'(MO);
                                else
                                    no_reg <= OCW'(cfg_out_reg);
                                i_reg          <= '0;
                                j_reg          <= '0;
                                o_reg          <= '0;
                                g_reg          <= '0;
                                comb_phase_reg <= 1'b0;
                                gbase_reg      <= '0;
                                xbase_reg      <= '0;
                                hbase_reg      <= WA'(GX);
                                bgbase_reg     <= WA'(BB);
                                bptr_reg       <= WA'(BB);
                                ggbase_reg     <= '0;
                                gptr_reg       <= '0;
                                state_reg      <= ST_GX;
                            end
                        end
                    end
                end
                ST_GX:
                begin
                    i_reg <= i_reg + IA'(1);
                    if (i_end)
                    begin
                        j_reg <= '0;
                        state_reg <= ST_GH;
                    end
                end
                ST_GH:
                begin
                    j_reg <= j_reg + OA'(1);
                    if (j_end)
                        state_reg <= ST_GB;
                end
                ST_GB:
                begin
                    state_reg <= ST_GWAIT;
                end
                ST_GWAIT:
                begin
                    if (mac_done)
                        state_reg <= ST_GWR;
                end
                ST_GWR:
                begin
                    i_reg <= '0;
                    j_reg <= '0;
                    state_reg <= ST_GX;
                    if (o_end)
                    begin
                        o_reg <= '0;
                        if (g_reg == GATE_LAST)
                        begin
                            g_reg          <= '0;
                            comb_phase_reg <= 1'b1;
                            p_reg          <= '0;
                            crptr_reg      <= '0;
                            state_reg      <= ST_CRD;
                        end
                        else
                        begin
                            g_reg      <= g_reg + 2'd1;
                            gbase_reg  <= gbase_reg + WA'(GW);
                            xbase_reg  <= gbase_reg + WA'(GW);
                            hbase_reg  <= gbase_reg + WA'(GW + GX);
                            bgbase_reg <= bgbase_reg + WA'(MO);
                            bptr_reg   <= bgbase_reg + WA'(MO);
                            ggbase_reg <= ggbase_reg + GA'(MO);
                            gptr_reg   <= ggbase_reg + GA'(MO);
                        end
                    end
                    else
                    begin
                        o_reg     <= o_reg + OA'(1);
                        xbase_reg <= xbase_reg + WA'(MI);
                        hbase_reg <= hbase_reg + WA'(MO);
                        bptr_reg  <= bptr_reg + WA'(1);
                        gptr_reg  <= gptr_reg + GA'(1);
                    end
                end
                ST_CRD:
                begin
                    // gate words f, i, z, o of this unit in turn
                    if (p_reg != 3'd0)
                        hold_reg[2'(p_reg - 3'd1)] <= gate_rd_reg;
                    if (p_reg == 3'd1)
                        c_hold_reg <= cell_rv_reg ? cell_rd_reg : 16'sd0;
                    crptr_reg <= crptr_reg + GA'(MO);
                    p_reg <= p_reg + 3'd1;
                    if (p_reg == 3'd4)
                        state_reg <= ST_CM1A;
                end
                ST_CM1A:
                begin
                    state_reg <= ST_CM1B;
                end
                ST_CM1B:
                begin
                    state_reg <= ST_CWAIT1;
                end
                ST_CWAIT1:
                begin
                    if (mac_done)
                        state_reg <= ST_CMAC2;
                end
                ST_CMAC2:
                begin
                    state_reg <= ST_CWAIT2;
                end
                ST_CWAIT2:
                begin
                    if (mac_done)
                        state_reg <= ST_COUT;
                end
                ST_COUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= mac_q;
                        out_index_reg <= 4'(o_reg);
                        out_last_reg  <= o_end;
                        if (o_end)
                        begin
                            ecount_reg     <= '0;
                            comb_phase_reg <= 1'b0;
                            o_reg          <= '0;
                            state_reg      <= ST_IDLE;
                        end
                        else
                        begin
                            o_reg     <= o_reg + OA'(1);
                            crptr_reg <= GA'(o_reg) + GA'(1);
                            p_reg     <= '0;
                            state_reg <= ST_CRD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_index_reg, out_value_reg};
    assign m_tlast  = out_last_reg;

endmodule
